/* src/bbc_pkg.sv */
`timescale 1ns / 1ps

package bbc_pkg;

	// Position field widths
	localparam int ROW_BITS = 16;
	localparam int COL_BITS = 14;
	localparam int POS_BITS = ROW_BITS + COL_BITS;

	// Operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	// Error kinds
	localparam logic [1:0] ERR_UNMATCHED = 2'd0;
	localparam logic [1:0] ERR_UNCLOSED  = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;

	// Bracket kinds
	localparam logic [1:0] KIND_ROUND  = 2'd0;
	localparam logic [1:0] KIND_SQUARE = 2'd1;
	localparam logic [1:0] KIND_CURLY  = 2'd2;

	// Byte codes
	localparam logic [7:0] CH_LPAREN   = 8'h28;
	localparam logic [7:0] CH_RPAREN   = 8'h29;
	localparam logic [7:0] CH_LSQUARE  = 8'h5B;
	localparam logic [7:0] CH_RSQUARE  = 8'h5D;
	localparam logic [7:0] CH_LCURLY   = 8'h7B;
	localparam logic [7:0] CH_RCURLY   = 8'h7D;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] BYTE_DEL    = 8'd127;
	localparam logic [7:0] BYTE_CONT_HI = 8'hBF;

	typedef struct packed {
		logic       operation;
		logic [7:0] byte_value;
	} src_t;

	typedef struct packed {
		logic [1:0]          error_kind;
		logic [1:0]          bracket_kind;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] column;
		logic                last_of_run;
	} rpt_t;

	// Controller to datapath
	typedef struct packed {
		logic byte_go;
		logic eof_go;
		logic pop;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic any_left;
		logic out_free;
	} sts_t;

endpackage

/* src/bbc_ctrl.sv */
`timescale 1ns / 1ps

module bbc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            src_valid,
	input  logic            operation,
	output logic            src_stall,
	input  bbc_pkg::sts_t   sts,
	output bbc_pkg::cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_POP  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign src_stall = !((state_q == ST_IDLE) && sts.out_free);
	assign accept    = src_valid && !src_stall;

	always_comb begin
		cmd.byte_go = accept && (operation == bbc_pkg::OP_BYTE);
		cmd.eof_go  = accept && (operation == bbc_pkg::OP_EOF);
		cmd.pop     = (state_q == ST_POP);
		cmd.emit    = (state_q == ST_EMIT) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.eof_go && sts.any_left)
					state_d = ST_POP;
			end
			ST_POP: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free)
					state_d = sts.any_left ? ST_POP : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* src/bbc_dp.sv */
`timescale 1ns / 1ps

module bbc_dp #(
	parameter int STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bbc_pkg::cmd_t cmd,
	input  logic [7:0]    byte_value,
	output bbc_pkg::sts_t sts,
	output logic          rpt_valid,
	input  logic          rpt_stall,
	output bbc_pkg::rpt_t rpt_item
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int ROW_W = bbc_pkg::ROW_BITS;
	localparam int COL_W = bbc_pkg::COL_BITS;
	localparam int POS_W = bbc_pkg::POS_BITS;

	logic [CNT_W-1:0] cnt_q [3];
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [POS_W-1:0] stack_mem [3][STACK_DEPTH];

	logic             is_open;
	logic             is_close;
	logic [1:0]       kind;
	logic [CNT_W-1:0] cnt_cur;
	logic             push_ok;
	logic             pop_ok;
	logic             byte_err;
	logic [1:0]       byte_err_kind;
	logic [IDX_W-1:0] push_idx;

	logic [1:0]       sel;
	logic [CNT_W-1:0] cnt_dec;
	logic [IDX_W-1:0] rd_idx;
	logic             last_pop;

	logic [POS_W-1:0] rd_pos_s1;
	logic [1:0]       rd_kind_s1;
	logic             rd_last_s1;

	logic             rpt_valid_q;
	bbc_pkg::rpt_t    rpt_q;
	logic             load;

	// Byte decode
	always_comb begin
		is_open  = 1'b0;
		is_close = 1'b0;
		kind     = bbc_pkg::KIND_ROUND;
		case (byte_value)
			bbc_pkg::CH_LPAREN: begin
				is_open = 1'b1;
				kind    = bbc_pkg::KIND_ROUND;
			end
			bbc_pkg::CH_LSQUARE: begin
				is_open = 1'b1;
				kind    = bbc_pkg::KIND_SQUARE;
			end
			bbc_pkg::CH_LCURLY: begin
				is_open = 1'b1;
				kind    = bbc_pkg::KIND_CURLY;
			end
			bbc_pkg::CH_RPAREN: begin
				is_close = 1'b1;
				kind     = bbc_pkg::KIND_ROUND;
			end
			bbc_pkg::CH_RSQUARE: begin
				is_close = 1'b1;
				kind     = bbc_pkg::KIND_SQUARE;
			end
			bbc_pkg::CH_RCURLY: begin
				is_close = 1'b1;
				kind     = bbc_pkg::KIND_CURLY;
			end
			default: ;
		endcase
	end

	assign cnt_cur  = cnt_q[kind];
	assign push_idx = cnt_cur[IDX_W-1:0];
	assign push_ok  = cmd.byte_go && is_open && (cnt_cur < CNT_W'(STACK_DEPTH));
	assign pop_ok   = cmd.byte_go && is_close && (cnt_cur != '0);
	assign byte_err = cmd.byte_go && ((is_open && !(cnt_cur < CNT_W'(STACK_DEPTH)))
		|| (is_close && (cnt_cur == '0)));
	assign byte_err_kind = is_open ? bbc_pkg::ERR_OVERFLOW : bbc_pkg::ERR_UNMATCHED;

	// Flush: round first, then square, then curly
	always_comb begin
		logic [2:0] rem;
		if (cnt_q[0] != '0)
			sel = bbc_pkg::KIND_ROUND;
		else if (cnt_q[1] != '0)
			sel = bbc_pkg::KIND_SQUARE;
		else
			sel = bbc_pkg::KIND_CURLY;
		cnt_dec = cnt_q[sel] - CNT_W'(1);
		rd_idx  = cnt_dec[IDX_W-1:0];
		for (int k = 0; k < 3; k++)
			rem[k] = (sel == 2'(k)) ? (cnt_dec != '0) : (cnt_q[k] != '0);
		last_pop = !(|rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				cnt_q[k] <= '0;
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (cmd.pop && (sel == 2'(k)))
					cnt_q[k] <= cnt_dec;
				else if (kind == 2'(k)) begin
					if (push_ok)
						cnt_q[k] <= cnt_q[k] + CNT_W'(1);
					else if (pop_ok)
						cnt_q[k] <= cnt_q[k] - CNT_W'(1);
				end
			end
		end
	end

	// Position stacks
	always_ff @(posedge clk) begin
		if (push_ok)
			stack_mem[kind][push_idx] <= {row_q, col_q};
		if (cmd.pop) begin
			rd_pos_s1  <= stack_mem[sel][rd_idx];
			rd_kind_s1 <= sel;
			rd_last_s1 <= last_pop;
		end
	end

	// Row and column, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= ROW_W'(1);
			col_q <= COL_W'(1);
		end else if (cmd.eof_go) begin
			row_q <= ROW_W'(1);
			col_q <= COL_W'(1);
		end else if (cmd.byte_go) begin
			if (byte_value == bbc_pkg::CH_NEWLINE) begin
				if (row_q != '1)
					row_q <= row_q + ROW_W'(1);
				col_q <= COL_W'(1);
			end else if ((byte_value < bbc_pkg::BYTE_DEL)
				|| (byte_value > bbc_pkg::BYTE_CONT_HI)) begin
				if (col_q != '1)
					col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Output register
	assign load = byte_err || cmd.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rpt_valid_q <= 1'b0;
		else if (load)
			rpt_valid_q <= 1'b1;
		else if (!rpt_stall)
			rpt_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rpt_q.error_kind   <= bbc_pkg::ERR_UNCLOSED;
			rpt_q.bracket_kind <= rd_kind_s1;
			rpt_q.row          <= rd_pos_s1[POS_W-1:COL_W];
			rpt_q.column       <= rd_pos_s1[COL_W-1:0];
			rpt_q.last_of_run  <= rd_last_s1;
		end else if (byte_err) begin
			rpt_q.error_kind   <= byte_err_kind;
			rpt_q.bracket_kind <= kind;
			rpt_q.row          <= row_q;
			rpt_q.column       <= col_q;
			rpt_q.last_of_run  <= 1'b1;
		end
	end

	assign rpt_valid    = rpt_valid_q;
	assign rpt_item     = rpt_q;
	assign sts.out_free = !rpt_valid_q || !rpt_stall;
	assign sts.any_left = (cnt_q[0] != '0) || (cnt_q[1] != '0) || (cnt_q[2] != '0);

endmodule

/* src/bracket_balance_checker.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// src      in   src_valid/src_stall  src_item   (operation, byte_value)
// rpt      out  rpt_valid/rpt_stall  rpt_item   (error_kind, bracket_kind, row, column,
//                                                last_of_run)
//
// A text byte's report, if any, shows in rpt the next cycle. At end of file, each
// leftover stack entry takes a registered stack read, then a load of the output
// register, which waits while rpt is stalled.
// Reset clears the stack counts, sets row and column to 1 and idles the sequencer;
// stack contents are not cleared, since only entries below a count are read.
// A stalled rpt holds its transaction, and src stalls until the output register
// is free and no flush is running.

module bracket_balance_checker #(
	parameter int STACK_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          src_valid,
	output logic          src_stall,
	input  bbc_pkg::src_t src_item,
	output logic          rpt_valid,
	input  logic          rpt_stall,
	output bbc_pkg::rpt_t rpt_item
);

	bbc_pkg::cmd_t cmd;
	bbc_pkg::sts_t sts;

	// Sequencer: accepts transactions, walks leftover entries at end of file
	bbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.operation (src_item.operation),
		.src_stall (src_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Stacks, position counters and the output register
	bbc_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.byte_value (src_item.byte_value),
		.sts        (sts),
		.rpt_valid  (rpt_valid),
		.rpt_stall  (rpt_stall),
		.rpt_item   (rpt_item)
	);

endmodule
